// File: rtl/vsmc_pkg.sv
// vsmc_pkg: shared types, codes and the mode transition table for the
// voice session mode controller; no dependencies
`default_nettype none

package vsmc_pkg;

    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 20;
    localparam int unsigned GEN_W       = 32;
    localparam int unsigned SINCE_W     = 20;
    localparam int unsigned ELAPSED_W   = 21;

    localparam logic [CFG_DATA_W-1:0] WAKE_COOLDOWN_RST  = 20'd2000;
    localparam logic [CFG_DATA_W-1:0] DIALOG_TIMEOUT_RST = 20'd10000;
    localparam logic [GEN_W-1:0]      GEN_RST            = 32'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_COOLDOWN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIALOG_TIMEOUT = 1'd1;

    typedef enum logic [3:0] {
        OP_TICK         = 4'd0,
        OP_SAMPLE       = 4'd1,
        OP_START        = 4'd2,
        OP_WAKE         = 4'd3,
        OP_DIALOG_START = 4'd4,
        OP_DIALOG_END   = 4'd5,
        OP_PTT_START    = 4'd6,
        OP_PTT_RELEASE  = 4'd7,
        OP_ERROR        = 4'd8,
        OP_STOP         = 4'd9
    } t_op;

    typedef enum logic [2:0] {
        M_STOPPED   = 3'd0,
        M_WAKE      = 3'd1,
        M_TO_DIALOG = 3'd2,
        M_DIALOG    = 3'd3,
        M_TO_WAKE   = 3'd4,
        M_PTT       = 3'd5,
        M_ERRREC    = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_STALE    = 3'd1,
        ST_COOLDOWN = 3'd2,
        ST_INVALID  = 3'd3,
        ST_IGNORED  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        RT_NONE   = 2'd0,
        RT_WAKE   = 2'd1,
        RT_DIALOG = 2'd2
    } t_route;

    typedef struct packed {
        logic [3:0]       op;
        logic [GEN_W-1:0] event_generation;
        logic             terminate_request;
        logic signed [15:0] sample;
    } t_in_item;

    typedef struct packed {
        t_mode              mode;
        logic [GEN_W-1:0]   generation;
        t_route             route;
        logic signed [15:0] sample_out;
        logic               post_dialog_start;
        logic [1:0]         post_terminal_count;
        logic               rec_begin;
        logic               rec_end;
        t_status            status;
    } t_out_item;

    // legal mode transitions
    function automatic logic f_allowed(input logic [2:0] from, input t_mode to);
        logic [7:0] row;
        row = 8'd0;
        case (from)
            M_STOPPED:   row[M_WAKE] = 1'b1;
            M_WAKE: begin
                row[M_TO_DIALOG] = 1'b1;
                row[M_PTT]       = 1'b1;
                row[M_STOPPED]   = 1'b1;
                row[M_ERRREC]    = 1'b1;
            end
            M_TO_DIALOG: begin
                row[M_DIALOG] = 1'b1;
                row[M_ERRREC] = 1'b1;
            end
            M_DIALOG: begin
                row[M_TO_WAKE] = 1'b1;
                row[M_ERRREC]  = 1'b1;
            end
            M_TO_WAKE: begin
                row[M_WAKE]   = 1'b1;
                row[M_ERRREC] = 1'b1;
            end
            M_PTT: begin
                row[M_TO_WAKE] = 1'b1;
                row[M_ERRREC]  = 1'b1;
            end
            M_ERRREC: begin
                row[M_WAKE]    = 1'b1;
                row[M_STOPPED] = 1'b1;
            end
            default: row = 8'd0;
        endcase
        return row[to];
    endfunction

endpackage

`default_nettype wire

// File: rtl/voice_session_mode_controller.sv
// voice_session_mode_controller: an input transfer reaches its result
// transfer through the input register, then the result register
// throughput one item per cycle while the result is not stalled; state is
// updated as an item leaves the input register, so items go back to back
// reset (synchronous, i_rst_n low) clears modes, timers, valids and sets
// generation to one and the config registers to their defaults
// depends on vsmc_pkg
`default_nettype none

module voice_session_mode_controller
    import vsmc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                  r_in_valid;
    t_in_item              r_in;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [CFG_DATA_W-1:0] r_wake_cooldown;
    logic [CFG_DATA_W-1:0] r_dialog_timeout;

    logic [2:0]            r_mode,      n_mode;
    logic [GEN_W-1:0]      r_gen,       n_gen;
    logic                  r_running,   n_running;
    logic                  r_armed,     n_armed;
    logic [SINCE_W-1:0]    r_since,     n_since;
    logic                  r_timer_on,  n_timer_on;
    logic [ELAPSED_W-1:0]  r_elapsed,   n_elapsed;
    t_out_item             n_out;

    logic                  w_out_free;
    logic                  w_proc;
    logic                  w_in_take;
    logic [GEN_W-1:0]      w_gen_inc;
    logic                  w_gen_match;
    logic                  w_err_a;
    logic                  w_err_b;
    logic [2:0]            w_err_m1;
    logic                  w_term_timeout;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_proc      = r_in_valid && w_out_free;
    assign o_in_stall  = r_in_valid && !w_out_free;
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_gen_inc   = (r_gen == {GEN_W{1'b1}}) ? GEN_RST : r_gen + GEN_RST;
    assign w_gen_match = (r_in.event_generation == r_gen);
    assign w_err_a     = f_allowed(r_mode, M_ERRREC);
    assign w_err_m1    = w_err_a ? M_ERRREC : r_mode;
    assign w_err_b     = f_allowed(w_err_m1, M_WAKE);

    always_comb begin
        n_mode     = r_mode;
        n_gen      = r_gen;
        n_running  = r_running;
        n_armed    = r_armed;
        n_since    = r_since;
        n_timer_on = r_timer_on;
        n_elapsed  = r_elapsed;
        w_term_timeout = 1'b0;

        n_out                     = '0;
        n_out.route               = RT_NONE;
        n_out.status              = ST_OK;

        case (r_in.op)
            OP_TICK: begin
                if (r_since != {SINCE_W{1'b1}}) begin
                    n_since = r_since + 1'b1;
                end
                if (r_timer_on && r_elapsed != {ELAPSED_W{1'b1}}) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
                if (r_running && r_mode == M_DIALOG && r_timer_on) begin
                    w_term_timeout = (n_elapsed > {1'b0, r_dialog_timeout});
                    n_out.post_terminal_count = {1'b0, w_term_timeout}
                                              + {1'b0, r_in.terminate_request};
                end
            end
            OP_SAMPLE: begin
                if (r_running) begin
                    if (r_mode == M_WAKE) begin
                        n_out.route = RT_WAKE;
                    end else if (r_mode == M_DIALOG || r_mode == M_PTT) begin
                        n_out.route = RT_DIALOG;
                    end
                end
                if (n_out.route != RT_NONE) begin
                    n_out.sample_out = r_in.sample;
                end
            end
            OP_START: begin
                if (r_running) begin
                    n_out.status = ST_IGNORED;
                end else begin
                    n_running = 1'b1;
                    if (f_allowed(r_mode, M_WAKE)) begin
                        n_mode = M_WAKE;
                    end else begin
                        n_out.status = ST_INVALID;
                    end
                end
            end
            OP_WAKE: begin
                if (!r_running) begin
                    n_out.status = ST_IGNORED;
                end else if (!w_gen_match) begin
                    n_out.status = ST_STALE;
                end else if (r_armed && r_since < r_wake_cooldown) begin
                    n_out.status = ST_COOLDOWN;
                end else begin
                    n_armed = 1'b1;
                    n_since = '0;
                    n_gen   = w_gen_inc;
                    if (r_mode == M_WAKE) begin
                        n_mode = M_TO_DIALOG;
                        n_out.post_dialog_start = 1'b1;
                    end
                end
            end
            OP_DIALOG_START: begin
                if (!r_running) begin
                    n_out.status = ST_IGNORED;
                end else if (!w_gen_match) begin
                    n_out.status = ST_STALE;
                end else if (r_mode == M_TO_DIALOG) begin
                    n_mode     = M_DIALOG;
                    n_timer_on = 1'b1;
                    n_elapsed  = '0;
                    n_out.rec_begin = 1'b1;
                end
            end
            OP_DIALOG_END: begin
                if (!r_running) begin
                    n_out.status = ST_IGNORED;
                end else if (!w_gen_match) begin
                    n_out.status = ST_STALE;
                end else begin
                    n_timer_on = 1'b0;
                    n_elapsed  = '0;
                    n_out.rec_end = 1'b1;
                    if (r_mode == M_DIALOG) begin
                        n_mode  = M_WAKE;
                        n_armed = 1'b1;
                        n_since = '0;
                    end
                end
            end
            OP_ERROR: begin
                if (!r_running) begin
                    n_out.status = ST_IGNORED;
                end else if (r_mode == M_STOPPED) begin
                    n_out.status = ST_INVALID;
                end else begin
                    n_armed = 1'b1;
                    n_since = '0;
                    n_mode  = w_err_b ? M_WAKE : w_err_m1;
                    if (!w_err_a || !w_err_b) begin
                        n_out.status = ST_INVALID;
                    end
                end
            end
            OP_STOP: begin
                if (!r_running) begin
                    n_out.status = ST_IGNORED;
                end else begin
                    n_running = 1'b0;
                    if (f_allowed(r_mode, M_STOPPED)) begin
                        n_mode = M_STOPPED;
                    end else begin
                        n_out.status = ST_INVALID;
                    end
                end
            end
            default: begin
                n_out.status = ST_IGNORED;
            end
        endcase

        n_out.mode       = t_mode'(n_mode);
        n_out.generation = n_gen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_wake_cooldown  <= WAKE_COOLDOWN_RST;
            r_dialog_timeout <= DIALOG_TIMEOUT_RST;
            r_mode           <= M_STOPPED;
            r_gen            <= GEN_RST;
            r_running        <= 1'b0;
            r_armed          <= 1'b0;
            r_since          <= '0;
            r_timer_on       <= 1'b0;
            r_elapsed        <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end

            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WAKE_COOLDOWN:  r_wake_cooldown  <= i_cfg_data;
                    CFG_DIALOG_TIMEOUT: r_dialog_timeout <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_proc) begin
                r_mode     <= n_mode;
                r_gen      <= n_gen;
                r_running  <= n_running;
                r_armed    <= n_armed;
                r_since    <= n_since;
                r_timer_on <= n_timer_on;
                r_elapsed  <= n_elapsed;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in;
        end
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != '0)
        else $error("generation reached zero");

    a_term_in_dialog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.post_terminal_count != 2'd0 |-> r_out.mode == M_DIALOG)
        else $error("termination request outside dialog mode");

    a_begin_starts_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && n_out.rec_begin |=> r_timer_on && r_elapsed == '0
            && r_mode == M_DIALOG)
        else $error("dialog begin without timer start");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_out_free |=> r_in_valid && $stable(r_in))
        else $error("input register lost a held item");

endmodule

`default_nettype wire

// File: sim/voice_session_mode_controller_tb.sv
// voice_session_mode_controller_tb: self-checking testbench with a scoreboard class
// that predicts every result transfer from the accepted input transfers
// depends on vsmc_pkg and voice_session_mode_controller
import vsmc_pkg::*;

class session_scoreboard;
    localparam logic [19:0] SINCE_TOP   = 20'hFFFFF;
    localparam logic [20:0] ELAPSED_TOP = 21'h1FFFFF;

    logic [19:0] cooldown_ms;
    logic [19:0] timeout_ms;
    t_mode       mode;
    logic [31:0] gen;
    bit          running;
    bit          armed;
    logic [19:0] since_ms;
    bit          timer_on;
    logic [20:0] talk_ms;
    t_out_item   pending_results[$];
    int          errors;

    function new();
        cooldown_ms = WAKE_COOLDOWN_RST;
        timeout_ms  = DIALOG_TIMEOUT_RST;
        mode        = M_STOPPED;
        gen         = GEN_RST;
        running     = 0;
        armed       = 0;
        since_ms    = '0;
        timer_on    = 0;
        talk_ms     = '0;
        errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [19:0] val);
        if (idx == CFG_WAKE_COOLDOWN) begin
            cooldown_ms = val;
        end else begin
            timeout_ms = val;
        end
    endfunction

    function logic [7:0] legal_moves(t_mode from);
        case (from)
            M_STOPPED:   return 8'd1 << M_WAKE;
            M_WAKE:      return (8'd1 << M_TO_DIALOG) | (8'd1 << M_PTT) |
                                (8'd1 << M_STOPPED) | (8'd1 << M_ERRREC);
            M_TO_DIALOG: return (8'd1 << M_DIALOG) | (8'd1 << M_ERRREC);
            M_DIALOG:    return (8'd1 << M_TO_WAKE) | (8'd1 << M_ERRREC);
            M_TO_WAKE:   return (8'd1 << M_WAKE) | (8'd1 << M_ERRREC);
            M_PTT:       return (8'd1 << M_TO_WAKE) | (8'd1 << M_ERRREC);
            M_ERRREC:    return (8'd1 << M_WAKE) | (8'd1 << M_STOPPED);
            default:     return 8'd0;
        endcase
    endfunction

    function bit move_to(t_mode to);
        logic [7:0] moves;
        moves = legal_moves(mode);
        if (moves[to]) begin
            mode = to;
            return 1;
        end
        return 0;
    endfunction

    function void accept_item(t_in_item it);
        t_out_item r;
        bit        to_err;
        bit        to_wake;
        r = '0;
        r.status = ST_OK;
        r.route = RT_NONE;
        if (it.op == OP_TICK) begin
            if (since_ms != SINCE_TOP) since_ms = since_ms + 20'd1;
            if (timer_on && talk_ms != ELAPSED_TOP) talk_ms = talk_ms + 21'd1;
            if (running && mode == M_DIALOG && timer_on) begin
                if (talk_ms > {1'b0, timeout_ms})
                    r.post_terminal_count = r.post_terminal_count + 2'd1;
                if (it.terminate_request)
                    r.post_terminal_count = r.post_terminal_count + 2'd1;
            end
        end else if (it.op == OP_SAMPLE) begin
            if (running) begin
                if (mode == M_WAKE) r.route = RT_WAKE;
                else if (mode == M_DIALOG || mode == M_PTT) r.route = RT_DIALOG;
            end
            if (r.route != RT_NONE) r.sample_out = it.sample;
        end else if (it.op == OP_START) begin
            if (running) begin
                r.status = ST_IGNORED;
            end else begin
                running = 1;
                if (!move_to(M_WAKE)) r.status = ST_INVALID;
            end
        end else if (!running || it.op == OP_PTT_START || it.op == OP_PTT_RELEASE ||
                     it.op > OP_STOP) begin
            r.status = ST_IGNORED;
        end else if (it.op == OP_WAKE) begin
            if (it.event_generation != gen) begin
                r.status = ST_STALE;
            end else if (armed && since_ms < cooldown_ms) begin
                r.status = ST_COOLDOWN;
            end else begin
                armed = 1;
                since_ms = '0;
                gen = gen + 32'd1;
                if (gen == 0) gen = 1;
                if (mode == M_WAKE) begin
                    void'(move_to(M_TO_DIALOG));
                    r.post_dialog_start = 1'b1;
                end
            end
        end else if (it.op == OP_DIALOG_START) begin
            if (it.event_generation != gen) begin
                r.status = ST_STALE;
            end else if (mode == M_TO_DIALOG) begin
                void'(move_to(M_DIALOG));
                timer_on = 1;
                talk_ms = '0;
                r.rec_begin = 1'b1;
            end
        end else if (it.op == OP_DIALOG_END) begin
            if (it.event_generation != gen) begin
                r.status = ST_STALE;
            end else begin
                timer_on = 0;
                talk_ms = '0;
                r.rec_end = 1'b1;
                if (mode == M_DIALOG) begin
                    void'(move_to(M_TO_WAKE));
                    armed = 1;
                    since_ms = '0;
                    void'(move_to(M_WAKE));
                end
            end
        end else if (it.op == OP_ERROR) begin
            if (mode == M_STOPPED) begin
                r.status = ST_INVALID;
            end else begin
                to_err = move_to(M_ERRREC);
                armed = 1;
                since_ms = '0;
                to_wake = move_to(M_WAKE);
                if (!to_err || !to_wake) r.status = ST_INVALID;
            end
        end else begin
            if (!move_to(M_STOPPED)) r.status = ST_INVALID;
            running = 0;
        end
        r.mode = mode;
        r.generation = gen;
        pending_results.push_back(r);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            report("unexpected result transfer", 32'd0, 32'd1);
        end else begin
            want = pending_results.pop_front();
            if (got.mode !== want.mode) report("mode", 32'(want.mode), 32'(got.mode));
            if (got.generation !== want.generation)
                report("generation", want.generation, got.generation);
            if (got.route !== want.route)
                report("route", 32'(want.route), 32'(got.route));
            if (got.sample_out !== want.sample_out)
                report("sample_out", 32'(unsigned'(want.sample_out)),
                       32'(unsigned'(got.sample_out)));
            if (got.post_dialog_start !== want.post_dialog_start)
                report("post_dialog_start", 32'(want.post_dialog_start),
                       32'(got.post_dialog_start));
            if (got.post_terminal_count !== want.post_terminal_count)
                report("post_terminal_count", 32'(want.post_terminal_count),
                       32'(got.post_terminal_count));
            if (got.rec_begin !== want.rec_begin)
                report("rec_begin", 32'(want.rec_begin), 32'(got.rec_begin));
            if (got.rec_end !== want.rec_end)
                report("rec_end", 32'(want.rec_end), 32'(got.rec_end));
            if (got.status !== want.status)
                report("status", 32'(want.status), 32'(got.status));
        end
    endfunction
endclass

module voice_session_mode_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              in_item = '0;
    logic                  o_out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             o_out;
    logic                  cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    session_scoreboard sb;
    bit idle_on = 0;
    bit hold_long = 0;
    int quiet_cycles = 0;

    voice_session_mode_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) sb.check_result(o_out);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver side: short random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                out_stall <= 1'b1;
                repeat (60) @(negedge i_clk);
                hold_long = 0;
                out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_item(input t_in_item it);
        @(negedge i_clk);
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.accept_item(it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item mk(input logic [3:0] op, input logic [31:0] g = 0,
                                    input bit term = 0, input logic signed [15:0] s = 0);
        t_in_item it;
        it.op = op;
        it.event_generation = g;
        it.terminate_request = term;
        it.sample = s;
        return it;
    endfunction

    task automatic run_directed();
        t_in_item seq[$];
        seq.push_back(mk(OP_WAKE, 1));
        seq.push_back(mk(OP_SAMPLE, 0, 0, 16'sh7FFF));
        seq.push_back(mk(OP_TICK, 0, 1));
        seq.push_back(mk(OP_START));
        seq.push_back(mk(OP_START));
        seq.push_back(mk(OP_SAMPLE, 32'hFFFFFFFF, 1, 16'sh8000));
        seq.push_back(mk(OP_WAKE, 0));
        seq.push_back(mk(OP_WAKE, 1));
        seq.push_back(mk(OP_SAMPLE, 0, 0, 16'sh1234));
        seq.push_back(mk(OP_STOP));
        seq.push_back(mk(OP_DIALOG_START, 2));
        seq.push_back(mk(OP_START));
        seq.push_back(mk(OP_DIALOG_START, 32'hFFFFFFFF));
        seq.push_back(mk(OP_DIALOG_START, 2));
        seq.push_back(mk(OP_WAKE, 2));
        repeat (3) seq.push_back(mk(OP_TICK, 0, 0));
        seq.push_back(mk(OP_WAKE, 2));
        seq.push_back(mk(OP_DIALOG_START, 3));
        repeat (3) seq.push_back(mk(OP_TICK, 0, 1));
        seq.push_back(mk(OP_SAMPLE, 0, 0, 16'sh8000));
        seq.push_back(mk(OP_PTT_START, 3));
        seq.push_back(mk(OP_PTT_RELEASE, 3));
        seq.push_back(mk(4'hF, 3));
        seq.push_back(mk(OP_DIALOG_END, 3));
        seq.push_back(mk(OP_DIALOG_END, 3));
        seq.push_back(mk(OP_ERROR));
        seq.push_back(mk(OP_STOP));
        seq.push_back(mk(OP_ERROR));
        foreach (seq[i]) push_item(seq[i]);
    endtask

    // mostly the next step of a normal session, the rest noise
    function automatic t_in_item rand_item();
        t_in_item    it;
        int unsigned p;
        p = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < 20) begin
            it.op = 4'($urandom_range(0, 15));
        end else if (!sb.running) begin
            it.op = OP_START;
        end else begin
            case (sb.mode)
                M_WAKE:      it.op = p < 4 ? OP_TICK : p < 7 ? OP_SAMPLE : p < 9 ? OP_WAKE : OP_STOP;
                M_TO_DIALOG: it.op = p < 6 ? OP_DIALOG_START : p < 8 ? OP_TICK : OP_SAMPLE;
                M_DIALOG:    it.op = p < 5 ? OP_TICK : p < 8 ? OP_SAMPLE :
                                     p < 9 ? OP_DIALOG_END : OP_ERROR;
                default:     it.op = OP_TICK;
            endcase
        end
        p = $urandom_range(0, 19);
        case (p)
            0:       it.event_generation = 32'd0;
            1:       it.event_generation = 32'hFFFFFFFF;
            2:       it.event_generation = sb.gen + 32'd1;
            3:       it.event_generation = sb.gen - 32'd1;
            4:       it.event_generation = $urandom;
            default: it.event_generation = sb.gen;
        endcase
        it.terminate_request = ($urandom_range(0, 7) == 0);
        p = $urandom_range(0, 19);
        it.sample = p == 0 ? 16'sh8000 : p == 1 ? 16'sh7FFF : 16'($urandom);
        return it;
    endfunction

    task automatic run_random(input int count, input bit with_hold);
        for (int i = 0; i < count; i++) begin
            push_item(rand_item());
            if (with_hold && i == count / 3) hold_long = 1;
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_WAKE_COOLDOWN, 20'd3);
        write_reg(CFG_DIALOG_TIMEOUT, 20'd5);
        run_directed();
        settle();

        idle_on = 1;
        run_random(250, 0);
        settle();

        write_reg(CFG_WAKE_COOLDOWN, 20'd0);
        write_reg(CFG_DIALOG_TIMEOUT, 20'd0);
        run_random(200, 1);
        settle();

        write_reg(CFG_WAKE_COOLDOWN, 20'hFFFFF);
        write_reg(CFG_DIALOG_TIMEOUT, 20'hFFFFF);
        run_random(150, 0);
        settle();

        write_reg(CFG_WAKE_COOLDOWN, 20'd20);
        write_reg(CFG_DIALOG_TIMEOUT, 20'd30);
        idle_on = 0;
        run_random(200, 0);
        settle();

        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
